@@ design/spg_pkg.sv @@
// Shared types and constants for the serial-programmed pulse generator.
package spg_pkg;

    localparam logic [7:0] CMD_PAUSE = 8'd0;
    localparam logic [7:0] CMD_PULSE = 8'd1;
    localparam logic [7:0] CMD_SAVE  = 8'd2;

    localparam logic [2:0] FRAME_STORE_LEN = 3'd1;
    localparam logic [2:0] FRAME_SET_LEN   = 3'd5;

    localparam int unsigned RESET_LENGTH = 10;
    localparam int unsigned TICKS_W      = 14;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic                    pulse_level;
        logic                    store_request;
        logic                    length_updated;
        logic [TICKS_W-1:0]      pause_ticks;
        logic [TICKS_W-1:0]      pulse_ticks;
    } t_out_item;

    // Decoded outcome of one received byte.
    typedef struct packed {
        logic store;
        logic set_pause;
        logic set_pulse;
    } t_frame_cmd;

endpackage

@@ design/spg_frame.sv @@
// Command frame assembler: gathers bytes and decodes completed frames.
module spg_frame #(
    parameter int unsigned MAX_LENGTH = 16383,
    parameter int unsigned LEN_W      = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_byte_valid,
    input  logic [7:0]          i_byte,
    output spg_pkg::t_frame_cmd o_cmd,
    output logic [LEN_W-1:0]    o_value
);

    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic [7:0]  r_frame [0:3];
    logic [2:0]  idx;
    logic [2:0]  cnt_inc;
    logic [7:0]  first;
    logic [31:0] raw;
    logic        over;

    // Count beyond a set frame restarts at the first slot.
    assign idx     = (r_count >= spg_pkg::FRAME_SET_LEN) ? 3'd0 : r_count;
    assign cnt_inc = idx + 3'd1;
    assign first   = (idx == 3'd0) ? i_byte : r_frame[0];
    assign raw     = {r_frame[1], r_frame[2], r_frame[3], i_byte};
    assign over    = raw > 32'(MAX_LENGTH);
    assign o_value = over ? LEN_W'(MAX_LENGTH) : raw[LEN_W-1:0];

    always_comb begin
        o_cmd   = '0;
        n_count = r_count;
        if (i_byte_valid) begin
            n_count = cnt_inc;
            if (cnt_inc == spg_pkg::FRAME_STORE_LEN && first == spg_pkg::CMD_SAVE) begin
                o_cmd.store = 1'b1;
                n_count     = 3'd0;
            end else if (cnt_inc == spg_pkg::FRAME_SET_LEN) begin
                o_cmd.set_pause = (first == spg_pkg::CMD_PAUSE);
                o_cmd.set_pulse = (first == spg_pkg::CMD_PULSE);
                n_count         = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Frame bytes hold the command and the first three length bytes; the last byte is used straight from the input.
    always_ff @(posedge i_clk) begin
        if (i_byte_valid && idx < 3'd4) begin
            r_frame[idx[1:0]] <= i_byte;
        end
    end

endmodule

@@ design/spg_timer.sv @@
// Period counter and length registers; derives the output level.
module spg_timer #(
    parameter int unsigned LEN_W = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  spg_pkg::t_frame_cmd i_cmd,
    input  logic [LEN_W-1:0]    i_value,
    output logic                o_level,
    output logic [LEN_W-1:0]    o_pause,
    output logic [LEN_W-1:0]    o_pulse
);

    localparam int unsigned PH_W = LEN_W + 1;

    logic [LEN_W-1:0] r_pause, n_pause;
    logic [LEN_W-1:0] r_pulse, n_pulse;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [PH_W-1:0]  total;
    logic [PH_W-1:0]  pos;
    logic [PH_W-1:0]  pos_inc;
    logic             level_now;
    logic             updated;

    assign total     = PH_W'(r_pause) + PH_W'(r_pulse);
    assign pos       = (r_phase >= total) ? '0 : r_phase;
    assign pos_inc   = pos + PH_W'(1);
    assign level_now = (total != '0) && (pos >= PH_W'(r_pause));
    assign updated   = i_cmd.set_pause || i_cmd.set_pulse;

    always_comb begin
        n_pause = i_cmd.set_pause ? i_value : r_pause;
        n_pulse = i_cmd.set_pulse ? i_value : r_pulse;
        n_phase = r_phase;
        o_level = level_now;
        if (i_tick) begin
            n_phase = (total == '0 || pos_inc >= total) ? '0 : pos_inc;
        end else if (updated) begin
            // Period restarts: level at position zero with the new lengths.
            n_phase = '0;
            o_level = (n_pause == '0) && (n_pulse != '0);
        end
    end

    assign o_pause = n_pause;
    assign o_pulse = n_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause <= LEN_W'(spg_pkg::RESET_LENGTH);
            r_pulse <= LEN_W'(spg_pkg::RESET_LENGTH);
            r_phase <= '0;
        end else begin
            r_pause <= n_pause;
            r_pulse <= n_pulse;
            r_phase <= n_phase;
        end
    end

endmodule

@@ design/serial_programmed_pulse_generator_core.sv @@
// Top level of the serial-programmed pulse generator.
//
// Usage notes:
//  - Input channel (i_in_valid / o_in_ready / i_in_item): each item is either a
//    received command byte (req_type 0) or one timer tick (req_type 1).
//  - Output channel (o_out_valid / i_out_ready / o_out_item): exactly one result
//    item per input item, in order: level, store/update flags, both lengths.
//  - Result: registered, and presented in the cycle after its item is accepted.
//  - Throughput: one item per cycle while i_out_ready is high. Decode, period count
//    and level are done in a single pass between the state and result registers.
//  - Stall: o_in_ready is high while the result register is empty or being
//    taken this cycle, so while a result waits no further item is accepted.
//  - Reset (synchronous, active low): frame empty, both lengths ten ticks,
//    period position zero, result register empty.
//  - Frames: byte 2 alone requests a settings store; command 0 or 1 followed
//    by a big-endian 32-bit length sets pause or pulse (clamped to MAX_LENGTH)
//    and restarts the period. Other commands are dropped.
//  - Result length fields show the low 14 bits of each length.
module serial_programmed_pulse_generator_core #(
    parameter int unsigned MAX_LENGTH = 16383
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spg_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spg_pkg::t_out_item o_out_item
);

    // Length width covers MAX_LENGTH and the reset value of ten.
    localparam int unsigned CLOG_W = $clog2(MAX_LENGTH + 1);
    localparam int unsigned LEN_W  = (CLOG_W > 4) ? CLOG_W : 4;
    localparam int unsigned EXT_W  = LEN_W + spg_pkg::TICKS_W;

    logic                r_out_valid;
    spg_pkg::t_out_item  r_out_item;
    spg_pkg::t_out_item  n_out_item;
    logic                accept;
    logic                tick;
    logic                byte_in;
    spg_pkg::t_frame_cmd cmd;
    logic [LEN_W-1:0]    value;
    logic                level;
    logic [LEN_W-1:0]    pause_len;
    logic [LEN_W-1:0]    pulse_len;
    logic [EXT_W-1:0]    pause_ext;
    logic [EXT_W-1:0]    pulse_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tick       = accept && (i_in_item.req_type == spg_pkg::REQ_TICK);
    assign byte_in    = accept && (i_in_item.req_type == spg_pkg::REQ_BYTE);

    spg_frame #(
        .MAX_LENGTH (MAX_LENGTH),
        .LEN_W      (LEN_W)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_in),
        .i_byte       (i_in_item.byte_value),
        .o_cmd        (cmd),
        .o_value      (value)
    );

    spg_timer #(
        .LEN_W (LEN_W)
    ) u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_cmd   (cmd),
        .i_value (value),
        .o_level (level),
        .o_pause (pause_len),
        .o_pulse (pulse_len)
    );

    // Lengths shown on the result fields are cut or widened to 14 bits.
    assign pause_ext = {{spg_pkg::TICKS_W{1'b0}}, pause_len};
    assign pulse_ext = {{spg_pkg::TICKS_W{1'b0}}, pulse_len};

    always_comb begin
        n_out_item                = '0;
        n_out_item.pulse_level    = level;
        n_out_item.store_request  = cmd.store;
        n_out_item.length_updated = cmd.set_pause || cmd.set_pulse;
        n_out_item.pause_ticks    = pause_ext[spg_pkg::TICKS_W-1:0];
        n_out_item.pulse_ticks    = pulse_ext[spg_pkg::TICKS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ tb/spg_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the pulse generator: predicts every result item and compares it.
module spg_result_checker #(
    parameter int unsigned MAX_LENGTH = 16383
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spg_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spg_pkg::t_out_item i_out_item,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending
);

    spg_pkg::t_out_item expected_q[$];
    logic [7:0]         frame_buf[5];
    logic [2:0]         frame_fill;
    int unsigned        pause_len;
    int unsigned        pulse_len;
    int unsigned        phase_pos;
    int unsigned        fail_cnt;

    // Advances the predicted generator by one item and returns its result.
    function automatic spg_pkg::t_out_item next_result(input spg_pkg::t_in_item it);
        spg_pkg::t_out_item res;
        int unsigned        period;
        int unsigned        len;
        logic [2:0]         slot;
        res = '0;
        period = pause_len + pulse_len;
        if (it.req_type == spg_pkg::REQ_TICK) begin
            if (period == 0) begin
                phase_pos = 0;
            end else begin
                if (phase_pos >= period) begin
                    phase_pos = 0;
                end
                res.pulse_level = (phase_pos >= pause_len);
                phase_pos++;
                if (phase_pos >= period) begin
                    phase_pos = 0;
                end
            end
        end else begin
            slot = (frame_fill >= spg_pkg::FRAME_SET_LEN) ? 3'd0 : frame_fill;
            frame_buf[slot] = it.byte_value;
            frame_fill = slot + 3'd1;
            if (frame_fill == spg_pkg::FRAME_STORE_LEN && frame_buf[0] == spg_pkg::CMD_SAVE) begin
                res.store_request = 1'b1;
                frame_fill = '0;
            end else if (frame_fill == spg_pkg::FRAME_SET_LEN) begin
                len = {frame_buf[1], frame_buf[2], frame_buf[3], frame_buf[4]};
                if (len > MAX_LENGTH) begin
                    len = MAX_LENGTH;
                end
                if (frame_buf[0] == spg_pkg::CMD_PAUSE) begin
                    pause_len = len;
                    res.length_updated = 1'b1;
                    phase_pos = 0;
                end else if (frame_buf[0] == spg_pkg::CMD_PULSE) begin
                    pulse_len = len;
                    res.length_updated = 1'b1;
                    phase_pos = 0;
                end
                frame_fill = '0;
            end
            // level the next tick would give; out-of-range position counts as zero
            period = pause_len + pulse_len;
            if (period != 0) begin
                res.pulse_level = ((phase_pos >= period) ? 0 : phase_pos) >= pause_len;
            end
        end
        res.pause_ticks = pause_len[spg_pkg::TICKS_W-1:0];
        res.pulse_ticks = pulse_len[spg_pkg::TICKS_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [spg_pkg::TICKS_W-1:0] want_v,
                                        input logic [spg_pkg::TICKS_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        spg_pkg::t_out_item want;
        if (!i_rst_n) begin
            expected_q.delete();
            foreach (frame_buf[k]) frame_buf[k] = '0;
            frame_fill = '0;
            pause_len  = spg_pkg::RESET_LENGTH;
            pulse_len  = spg_pkg::RESET_LENGTH;
            phase_pos  = 0;
            fail_cnt   = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(next_result(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("pulse_level", spg_pkg::TICKS_W'(want.pulse_level),
                                spg_pkg::TICKS_W'(i_out_item.pulse_level));
                    check_field("store_request", spg_pkg::TICKS_W'(want.store_request),
                                spg_pkg::TICKS_W'(i_out_item.store_request));
                    check_field("length_updated", spg_pkg::TICKS_W'(want.length_updated),
                                spg_pkg::TICKS_W'(i_out_item.length_updated));
                    check_field("pause_ticks", want.pause_ticks, i_out_item.pause_ticks);
                    check_field("pulse_ticks", want.pulse_ticks, i_out_item.pulse_ticks);
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_q.size();
    end

endmodule

@@ tb/tb_serial_programmed_pulse_generator_core.sv @@
`timescale 1ns / 100ps
// Top of the pulse generator testbench: clock, reset, stimulus and verdict.
module tb_serial_programmed_pulse_generator_core;

    localparam int unsigned MAX_LENGTH   = 16383;
    localparam int unsigned TOTAL_ITEMS  = 675;    // directed part plus about 650 random
    localparam int unsigned CALM_ITEMS   = 100;    // closing stretch with no idling
    localparam int unsigned HOLD_AT      = 250;
    localparam int unsigned DRAIN_AT     = 400;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    spg_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    spg_pkg::t_out_item out_item;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    int unsigned frame_phase = 0;  // bytes already gathered into the current frame
    bit          gaps_on     = 1'b1;
    bit          calm        = 1'b0;
    bit          hold_req    = 1'b0;
    bit          hold_active = 1'b0;

    serial_programmed_pulse_generator_core #(
        .MAX_LENGTH (MAX_LENGTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    spg_result_checker #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest correct run (every item waiting out the
    // longest sender gap and receiver stall, plus the long hold-off).
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offers one item and holds it until it is taken. A random gap may come first,
    // with valid low. The byte-alignment count mirrors the block's framing rule so
    // that well-formed frames can be lined up after noise.
    task automatic send_item(input logic kind, input logic [7:0] val);
        spg_pkg::t_in_item it;
        it.req_type   = kind;
        it.byte_value = val;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (kind == spg_pkg::REQ_BYTE) begin
            if (frame_phase == 0 && val == spg_pkg::CMD_SAVE) begin
                frame_phase = 0;
            end else begin
                frame_phase = (frame_phase + 1) % spg_pkg::FRAME_SET_LEN;
            end
        end
    endtask

    task automatic send_tick();
        // byte field is don't-care on ticks, so keep it moving
        send_item(spg_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [7:0] val);
        send_item(spg_pkg::REQ_BYTE, val);
    endtask

    // Pads a broken frame out with junk bytes so the next byte starts a frame.
    task automatic realign();
        while (frame_phase != 0) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [31:0] len,
                              input bit mixed_ticks);
        realign();
        send_byte(cmd);
        for (int i = 3; i >= 0; i--) begin
            // ticks may fall between bytes without breaking the frame
            if (mixed_ticks && $urandom_range(0, 5) == 0) send_tick();
            send_byte(len[8*i +: 8]);
        end
    endtask

    task automatic send_store();
        realign();
        send_byte(spg_pkg::CMD_SAVE);
    endtask

    // Mostly short lengths so periods wrap often; some zero, clamped and near-limit.
    function automatic logic [31:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'd0;
            1:       return $urandom;
            2:       return $urandom_range(MAX_LENGTH - 3, MAX_LENGTH + 3);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // Receiver: random stalls and ready stretches, one long hold-off on request,
    // and always ready in the closing stretch.
    initial begin
        forever begin
            if (calm) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else if (hold_req) begin
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else begin
                if ($urandom_range(0, 2) != 0) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 200)) @(posedge clk);
                end else begin
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
            end
        end
    end

    initial begin
        int unsigned pick;
        logic [7:0]  cmd;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ticks from reset lengths, a store request, zero pause,
        // both lengths zero (level held low), a clamped length, an unknown command.
        send_tick();
        send_tick();
        send_store();
        send_frame(spg_pkg::CMD_PAUSE, 32'd0, 1'b0);
        send_tick();
        send_frame(spg_pkg::CMD_PULSE, 32'd0, 1'b0);
        send_tick();
        send_frame(spg_pkg::CMD_PULSE, 32'hFFFF_FFFF, 1'b0);
        send_frame(8'hFF, 32'h0000_0005, 1'b0);

        // Random: mostly well-formed frames and tick runs, some noise and broken frames.
        while (items_sent < TOTAL_ITEMS) begin
            if (!hold_active && !hold_req && items_sent >= HOLD_AT
                && items_sent < HOLD_AT + 40) begin
                // receiver holds off while items keep coming, so input stalls
                gaps_on  = 1'b0;
                in_valid <= 1'b0;
                hold_req = 1'b1;
                wait (hold_active);
                repeat (8) send_tick();
                send_frame(spg_pkg::CMD_PAUSE, pick_length(), 1'b0);
                repeat (8) send_tick();
            end
            if (items_sent >= DRAIN_AT && items_sent < DRAIN_AT + 40 && pending != 0) begin
                // sender pauses until every outstanding result has come back
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            if (items_sent + CALM_ITEMS >= TOTAL_ITEMS) begin
                calm    = 1'b1;
                gaps_on = 1'b0;
            end else begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end

            pick = $urandom_range(0, 19);
            if (pick <= 6) begin
                repeat ($urandom_range(1, 16)) send_tick();
            end else if (pick <= 13) begin
                cmd = ($urandom_range(0, 1) == 0) ? spg_pkg::CMD_PAUSE : spg_pkg::CMD_PULSE;
                send_frame(cmd, pick_length(), $urandom_range(0, 2) == 0);
            end else if (pick == 14) begin
                send_store();
            end else if (pick <= 16) begin
                send_frame(8'($urandom_range(spg_pkg::CMD_SAVE + 1, 255)), $urandom, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
